FILE: rtl/tif_pkg.sv
// Types and constants shared by the tape image file parser modules.
package tif_pkg;

   localparam logic [1:0] KIND_DROP   = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_BODY   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [1:0] FTYPE_NONE = 2'd0;
   localparam logic [1:0] FTYPE_A    = 2'd1;
   localparam logic [1:0] FTYPE_B    = 2'd2;
   localparam logic [1:0] FTYPE_M    = 2'd3;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_END_NAME    = 3'd1;
   localparam logic [2:0] ERR_BAD_START   = 3'd2;
   localparam logic [2:0] ERR_END_TYPE    = 3'd3;
   localparam logic [2:0] ERR_END_A_HDR   = 3'd4;
   localparam logic [2:0] ERR_END_BM_HDR  = 3'd5;
   localparam logic [2:0] ERR_BAD_TYPE    = 3'd6;
   localparam logic [2:0] ERR_END_PAYLOAD = 3'd7;

   localparam logic [7:0] CHR_SYNC  = 8'hA5;
   localparam logic [7:0] CHR_QUOTE = 8'h22;
   localparam logic [7:0] CHR_A     = 8'h41;
   localparam logic [7:0] CHR_B     = 8'h42;
   localparam logic [7:0] CHR_M     = 8'h4D;

   localparam logic [16:0] EXTRA_A = 17'd12;
   localparam logic [16:0] EXTRA_B = 17'd3;
   localparam logic [16:0] EXTRA_M = 17'd7;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_out;
      logic [1:0] file_type;
      logic       name_done;
      logic       body_last;
      logic [2:0] error_code;
      logic       image_done;
   } result_type;

endpackage

FILE: rtl/tif_step.sv
// Parser state and the per-byte next-state and result logic.
module tif_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           data_byte,
   input  logic                 is_end,
   output tif_pkg::result_type  result
);

   typedef enum logic [3:0] {
      PH_START    = 4'd0,
      PH_TRAIL    = 4'd1,
      PH_AFTER_A5 = 4'd2,
      PH_NAME     = 4'd3,
      PH_TYPE     = 4'd4,
      PH_HEADER   = 4'd5,
      PH_BODY     = 4'd6,
      PH_DONE     = 4'd7,
      PH_HALT     = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [16:0] remain_ff, remain_in;
   logic [1:0]  ftype_ff, ftype_in;
   logic [2:0]  err_ff, err_in;

   logic        go_start;
   logic        go_type;
   logic        type_named;
   logic        is_a;
   logic [2:0]  lo_at;
   logic [16:0] extra;
   logic [16:0] remain_dec;
   logic        fail;
   logic [2:0]  fail_code;

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      len_lo_in  = len_lo_ff;
      remain_in  = remain_ff;
      ftype_in   = ftype_ff;
      err_in     = err_ff;
      go_start   = 1'b0;
      go_type    = 1'b0;
      type_named = 1'b0;
      fail       = 1'b0;
      fail_code  = tif_pkg::ERR_NONE;
      result     = '0;
      result.kind = tif_pkg::KIND_STATUS;

      is_a       = (ftype_ff == tif_pkg::FTYPE_A);
      lo_at      = is_a ? 3'd3 : 3'd1;
      extra      = is_a ? tif_pkg::EXTRA_A :
                   ((ftype_ff == tif_pkg::FTYPE_B) ? tif_pkg::EXTRA_B : tif_pkg::EXTRA_M);
      remain_dec = remain_ff - 17'd1;

      unique case (phase_ff)
         PH_HALT: begin
            result.error_code = err_ff;
         end
         PH_DONE: begin
            result.image_done = 1'b1;
         end
         PH_START, PH_TRAIL: begin
            if (is_end) begin
               phase_in          = PH_DONE;
               result.image_done = 1'b1;
            end else if (data_byte == 8'd0 && phase_ff == PH_TRAIL) begin
               result.kind = tif_pkg::KIND_DROP;
            end else if (data_byte == tif_pkg::CHR_SYNC) begin
               phase_in    = PH_AFTER_A5;
               result.kind = tif_pkg::KIND_DROP;
            end else begin
               go_start = 1'b1;
            end
         end
         PH_AFTER_A5: begin
            if (is_end) begin
               fail      = 1'b1;
               fail_code = tif_pkg::ERR_BAD_START;
            end else begin
               go_start = 1'b1;
            end
         end
         PH_NAME: begin
            if (is_end || data_byte == 8'd0) begin
               fail      = 1'b1;
               fail_code = tif_pkg::ERR_END_NAME;
            end else if (data_byte == tif_pkg::CHR_QUOTE) begin
               phase_in         = PH_TYPE;
               result.kind      = tif_pkg::KIND_DROP;
               result.name_done = 1'b1;
            end else begin
               result.kind     = tif_pkg::KIND_NAME;
               result.byte_out = data_byte;
            end
         end
         PH_TYPE: begin
            if (is_end) begin
               fail      = 1'b1;
               fail_code = tif_pkg::ERR_END_TYPE;
            end else begin
               go_type = 1'b1;
            end
         end
         PH_HEADER: begin
            if (is_end) begin
               fail      = 1'b1;
               fail_code = is_a ? tif_pkg::ERR_END_A_HDR : tif_pkg::ERR_END_BM_HDR;
            end else begin
               if (hdr_idx_ff == lo_at) begin
                  len_lo_in = data_byte;
               end else if (hdr_idx_ff == lo_at + 3'd1) begin
                  remain_in = {1'b0, data_byte, len_lo_ff} + extra;
                  phase_in  = PH_BODY;
               end
               hdr_idx_in      = hdr_idx_ff + 3'd1;
               result.kind     = tif_pkg::KIND_BODY;
               result.byte_out = data_byte;
            end
         end
         PH_BODY: begin
            if (is_end) begin
               fail      = 1'b1;
               fail_code = tif_pkg::ERR_END_PAYLOAD;
            end else begin
               remain_in        = remain_dec;
               result.kind      = tif_pkg::KIND_BODY;
               result.byte_out  = data_byte;
               result.body_last = (remain_dec == 17'd0);
               if (remain_dec == 17'd0) begin
                  phase_in = PH_TRAIL;
               end
            end
         end
         default: begin
            result.kind = tif_pkg::KIND_STATUS;
         end
      endcase

      // A new file begins: a nameless type A file goes straight to its type letter.
      if (go_start) begin
         ftype_in = tif_pkg::FTYPE_NONE;
         if (data_byte == tif_pkg::CHR_A) begin
            go_type    = 1'b1;
            type_named = 1'b1;
         end else if (data_byte == tif_pkg::CHR_QUOTE) begin
            phase_in    = PH_NAME;
            result.kind = tif_pkg::KIND_DROP;
         end else begin
            fail      = 1'b1;
            fail_code = tif_pkg::ERR_BAD_START;
         end
      end

      if (go_type) begin
         if (data_byte == tif_pkg::CHR_A || data_byte == tif_pkg::CHR_B ||
             data_byte == tif_pkg::CHR_M) begin
            if (data_byte == tif_pkg::CHR_A) begin
               ftype_in = tif_pkg::FTYPE_A;
            end else if (data_byte == tif_pkg::CHR_B) begin
               ftype_in = tif_pkg::FTYPE_B;
            end else begin
               ftype_in = tif_pkg::FTYPE_M;
            end
            hdr_idx_in       = 3'd1;
            len_lo_in        = 8'd0;
            phase_in         = PH_HEADER;
            result.kind      = tif_pkg::KIND_BODY;
            result.byte_out  = data_byte;
            result.name_done = type_named;
         end else begin
            fail      = 1'b1;
            fail_code = tif_pkg::ERR_BAD_TYPE;
         end
      end

      if (fail) begin
         phase_in          = PH_HALT;
         err_in            = fail_code;
         result            = '0;
         result.kind       = tif_pkg::KIND_STATUS;
         result.error_code = fail_code;
      end

      result.file_type = ftype_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         hdr_idx_ff <= 3'd0;
         len_lo_ff  <= 8'd0;
         remain_ff  <= 17'd0;
         ftype_ff   <= tif_pkg::FTYPE_NONE;
         err_ff     <= tif_pkg::ERR_NONE;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         len_lo_ff  <= len_lo_in;
         remain_ff  <= remain_in;
         ftype_ff   <= ftype_in;
         err_ff     <= err_in;
      end
   end

endmodule

FILE: rtl/tape_image_file_parser.sv
// Top level of the tape image file parser: input register, parser step and result register.
//
//   Channel  Direction  Payload
//   req_     in         data_byte[7:0], is_end
//   rsp_     out        kind, byte_out, file_type, name_done, body_last, error_code, image_done
//
// One request is taken every cycle while the result register is not stalled; its result passes
// from the input register through the parser step into the result register.
// A stalled result holds the result register; the input register still takes one
// further request. Reset is synchronous and returns the parser to the start of an image.
module tape_image_file_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_byte_out,
   output logic [1:0] rsp_file_type,
   output logic       rsp_name_done,
   output logic       rsp_body_last,
   output logic [2:0] rsp_error_code,
   output logic       rsp_image_done
);

   logic                in_vld_ff;
   logic [7:0]          in_byte_ff;
   logic                in_end_ff;
   logic                out_vld_ff;
   tif_pkg::result_type out_res_ff;
   tif_pkg::result_type step_res;
   logic                advance;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   tif_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .is_end    (in_end_ff),
      .result    (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_is_end;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_kind       = out_res_ff.kind;
   assign rsp_byte_out   = out_res_ff.byte_out;
   assign rsp_file_type  = out_res_ff.file_type;
   assign rsp_name_done  = out_res_ff.name_done;
   assign rsp_body_last  = out_res_ff.body_last;
   assign rsp_error_code = out_res_ff.error_code;
   assign rsp_image_done = out_res_ff.image_done;

endmodule

FILE: tb/sv/tb_tape_image_file_parser.sv
// Self-checking testbench for the tape image file parser, fed with tape images built at random.
`timescale 1ns / 100ps

module tb_tape_image_file_parser;

   localparam int WHOLE       = 1 << 30;
   localparam int HOLD_CYCLES = 300;

   // An empty-named B file, trailing zeros, then a synced M file, both of minimum length.
   localparam logic [8*25-1:0] OPENING = {
      tif_pkg::CHR_QUOTE, tif_pkg::CHR_QUOTE, tif_pkg::CHR_B, 8'h00, 8'h00, 8'hFF, 8'h00,
      tif_pkg::CHR_SYNC, 8'h00, 8'h00,
      tif_pkg::CHR_SYNC, tif_pkg::CHR_QUOTE, 8'hFF, 8'h01, tif_pkg::CHR_QUOTE, tif_pkg::CHR_M,
      8'h00, 8'h00,
      tif_pkg::CHR_QUOTE, tif_pkg::CHR_A, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h55};

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } tape_item_type;

   typedef enum int {
      CLOSE_CLEAN, CLOSE_END_IN_NAME, CLOSE_ZERO_IN_NAME, CLOSE_BAD_START,
      CLOSE_BAD_AFTER_SYNC, CLOSE_END_BEFORE_TYPE, CLOSE_END_IN_A_HEADER,
      CLOSE_END_IN_BM_HEADER, CLOSE_BAD_TYPE, CLOSE_END_IN_BODY, CLOSE_ZERO_FIRST
   } image_close_type;

   class image_split_checker;
      typedef enum logic [3:0] {
         ST_FIRST, ST_TRAIL, ST_SYNCED, ST_NAME, ST_TYPE, ST_HEADER, ST_BODY, ST_DONE, ST_HALTED
      } parse_state_type;

      parse_state_type     state;
      logic [2:0]          halt_code;
      logic [2:0]          header_pos;
      logic [7:0]          length_low;
      logic [16:0]         body_left;
      logic [1:0]          file_type;
      tif_pkg::result_type awaited_results[$];
      int                  mismatches;
      int                  results_checked;
      int                  name_bytes;
      int                  body_bytes;
      int                  files_closed;

      function new();
         state = ST_FIRST;
         halt_code = tif_pkg::ERR_NONE;
         header_pos = '0;
         length_low = '0;
         body_left = '0;
         file_type = tif_pkg::FTYPE_NONE;
         mismatches = 0;
         results_checked = 0;
         name_bytes = 0;
         body_bytes = 0;
         files_closed = 0;
      endfunction

      function tif_pkg::result_type halt_with(logic [2:0] code);
         tif_pkg::result_type r;
         r = '0;
         state = ST_HALTED;
         halt_code = code;
         r.kind = tif_pkg::KIND_STATUS;
         r.error_code = code;
         return r;
      endfunction

      function tif_pkg::result_type take_type(logic [7:0] b, logic named_done);
         tif_pkg::result_type r;
         r = '0;
         if (b == tif_pkg::CHR_A) file_type = tif_pkg::FTYPE_A;
         else if (b == tif_pkg::CHR_B) file_type = tif_pkg::FTYPE_B;
         else if (b == tif_pkg::CHR_M) file_type = tif_pkg::FTYPE_M;
         else return halt_with(tif_pkg::ERR_BAD_TYPE);
         header_pos = 3'd1;
         length_low = '0;
         state = ST_HEADER;
         r.kind = tif_pkg::KIND_BODY;
         r.byte_out = b;
         r.name_done = named_done;
         return r;
      endfunction

      function tif_pkg::result_type begin_file(logic [7:0] b);
         tif_pkg::result_type r;
         r = '0;
         file_type = tif_pkg::FTYPE_NONE;
         if (b == tif_pkg::CHR_A) return take_type(b, 1'b1);
         if (b != tif_pkg::CHR_QUOTE) return halt_with(tif_pkg::ERR_BAD_START);
         state = ST_NAME;
         r.kind = tif_pkg::KIND_DROP;
         return r;
      endfunction

      function tif_pkg::result_type predict(logic [7:0] b, logic fin);
         tif_pkg::result_type r;
         logic                is_a;
         logic [2:0]          low_at;
         r = '0;
         r.kind = tif_pkg::KIND_STATUS;
         is_a = (file_type == tif_pkg::FTYPE_A);
         low_at = is_a ? 3'd3 : 3'd1;
         case (state)
            ST_HALTED: r.error_code = halt_code;
            ST_DONE: r.image_done = 1'b1;
            ST_FIRST, ST_TRAIL: begin
               if (fin) begin
                  state = ST_DONE;
                  r.image_done = 1'b1;
               end else if (b == 8'h00 && state == ST_TRAIL) begin
                  r.kind = tif_pkg::KIND_DROP;
               end else if (b == tif_pkg::CHR_SYNC) begin
                  state = ST_SYNCED;
                  r.kind = tif_pkg::KIND_DROP;
               end else begin
                  r = begin_file(b);
               end
            end
            ST_SYNCED: begin
               if (fin) r = halt_with(tif_pkg::ERR_BAD_START);
               else r = begin_file(b);
            end
            ST_NAME: begin
               if (fin || b == 8'h00) begin
                  r = halt_with(tif_pkg::ERR_END_NAME);
               end else if (b == tif_pkg::CHR_QUOTE) begin
                  state = ST_TYPE;
                  r.kind = tif_pkg::KIND_DROP;
                  r.name_done = 1'b1;
               end else begin
                  r.kind = tif_pkg::KIND_NAME;
                  r.byte_out = b;
               end
            end
            ST_TYPE: begin
               if (fin) r = halt_with(tif_pkg::ERR_END_TYPE);
               else r = take_type(b, 1'b0);
            end
            ST_HEADER: begin
               if (fin) begin
                  r = halt_with(is_a ? tif_pkg::ERR_END_A_HDR : tif_pkg::ERR_END_BM_HDR);
               end else begin
                  if (header_pos == low_at) begin
                     length_low = b;
                  end else if (header_pos == low_at + 3'd1) begin
                     body_left = {1'b0, b, length_low}
                               + (is_a ? tif_pkg::EXTRA_A :
                                  (file_type == tif_pkg::FTYPE_B ? tif_pkg::EXTRA_B :
                                                                   tif_pkg::EXTRA_M));
                     state = ST_BODY;
                  end
                  header_pos = header_pos + 3'd1;
                  r.kind = tif_pkg::KIND_BODY;
                  r.byte_out = b;
               end
            end
            ST_BODY: begin
               if (fin) begin
                  r = halt_with(tif_pkg::ERR_END_PAYLOAD);
               end else begin
                  body_left = body_left - 17'd1;
                  r.kind = tif_pkg::KIND_BODY;
                  r.byte_out = b;
                  r.body_last = (body_left == '0);
                  if (r.body_last) state = ST_TRAIL;
               end
            end
            default: ;
         endcase
         r.file_type = file_type;
         return r;
      endfunction

      function void note_request(logic [7:0] b, logic fin);
         tif_pkg::result_type r;
         r = predict(b, fin);
         if (r.kind == tif_pkg::KIND_NAME) name_bytes++;
         if (r.kind == tif_pkg::KIND_BODY) body_bytes++;
         if (r.body_last) files_closed++;
         awaited_results.push_back(r);
      endfunction

      function int outstanding();
         return awaited_results.size();
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("MISMATCH %s", what);
      endtask

      task compare_field(string field, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                             results_checked, field, got, want));
      endtask

      task check_result(tif_pkg::result_type got);
         tif_pkg::result_type want;
         results_checked++;
         if (awaited_results.size() == 0) begin
            report($sformatf("result %0d arrived with no request outstanding", results_checked));
            return;
         end
         want = awaited_results.pop_front();
         compare_field("kind", 8'(got.kind), 8'(want.kind));
         compare_field("byte_out", got.byte_out, want.byte_out);
         compare_field("file_type", 8'(got.file_type), 8'(want.file_type));
         compare_field("name_done", 8'(got.name_done), 8'(want.name_done));
         compare_field("body_last", 8'(got.body_last), 8'(want.body_last));
         compare_field("error_code", 8'(got.error_code), 8'(want.error_code));
         compare_field("image_done", 8'(got.image_done), 8'(want.image_done));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_is_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_byte_out;
   logic [1:0] rsp_file_type;
   logic       rsp_name_done;
   logic       rsp_body_last;
   logic [2:0] rsp_error_code;
   logic       rsp_image_done;

   tape_item_type      tape_items[$];
   image_split_checker sb;

   tape_image_file_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_is_end     (req_is_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_file_type  (rsp_file_type),
      .rsp_name_done  (rsp_name_done),
      .rsp_body_last  (rsp_body_last),
      .rsp_error_code (rsp_error_code),
      .rsp_image_done (rsp_image_done)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void put_item(logic [7:0] b, logic fin);
      tape_item_type it;
      it.data = b;
      it.fin = fin;
      tape_items.push_back(it);
   endfunction

   function automatic void put_byte(logic [7:0] b);
      put_item(b, 1'b0);
   endfunction

   function automatic void put_end();
      put_item(random_byte(), 1'b1);
   endfunction

   function automatic int body_extra(logic [7:0] letter);
      if (letter == tif_pkg::CHR_A) return int'(tif_pkg::EXTRA_A);
      if (letter == tif_pkg::CHR_B) return int'(tif_pkg::EXTRA_B);
      return int'(tif_pkg::EXTRA_M);
   endfunction

   function automatic int file_head(bit named, logic [7:0] letter, int name_len);
      return (named ? name_len + 2 : 0) + 1 + (letter == tif_pkg::CHR_A ? 4 : 2);
   endfunction

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(0, 2))
         0: return tif_pkg::CHR_A;
         1: return tif_pkg::CHR_B;
         default: return tif_pkg::CHR_M;
      endcase
   endfunction

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(0, 7);
      if (roll < 97) return $urandom_range(8, 255);
      return $urandom_range(256, 700);
   endfunction

   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Builds one file and keeps only its first cut items, which lets a file be broken off.
   function automatic void put_file(bit sync, bit named, logic [7:0] letter, int name_len,
                                    logic [15:0] length, int cut);
      tape_item_type f[$];
      tape_item_type it;
      it.fin = 1'b0;
      if (named) begin
         it.data = tif_pkg::CHR_QUOTE;
         f.push_back(it);
         repeat (name_len) begin
            do it.data = random_byte();
            while (it.data == 8'h00 || it.data == tif_pkg::CHR_QUOTE);
            f.push_back(it);
         end
         it.data = tif_pkg::CHR_QUOTE;
         f.push_back(it);
      end
      it.data = letter;
      f.push_back(it);
      if (letter == tif_pkg::CHR_A) begin
         repeat (2) begin
            it.data = random_byte();
            f.push_back(it);
         end
      end
      it.data = length[7:0];
      f.push_back(it);
      it.data = length[15:8];
      f.push_back(it);
      repeat (int'(length) + body_extra(letter)) begin
         it.data = random_byte();
         f.push_back(it);
      end
      if (sync) put_byte(tif_pkg::CHR_SYNC);
      for (int i = 0; i < f.size() && i < cut; i++) tape_items.push_back(f[i]);
   endfunction

   task offer(tape_item_type it, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= it.data;
      req_is_end <= it.fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(it.data, it.fin);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_kind, rsp_byte_out, rsp_file_type, rsp_name_done,
                          rsp_body_last, rsp_error_code, rsp_image_done});
   end

   initial begin
      image_close_type closing;
      int              n;
      int              len;
      int              gap;
      int              tx_calm;
      int              big_at;
      int              file_no;
      int              base;
      logic [7:0]      letter;
      logic [7:0]      c;
      bit              named;
      bit              sync;

      sb = new();
      closing = image_close_type'($urandom_range(0, 10));
      if (closing == CLOSE_ZERO_FIRST) put_byte(8'h00);
      for (int i = 24; i >= 0; i--) put_byte(OPENING[8*i +: 8]);

      big_at = $urandom_range(1, 8);
      file_no = 0;
      base = tape_items.size();
      while (tape_items.size() - base < 650) begin
         if (file_no == big_at) begin
            put_file(1'b0, ($urandom_range(0, 1) == 1), tif_pkg::CHR_A, 3, 16'h0104, WHOLE);
         end else begin
            letter = pick_letter();
            named = (letter != tif_pkg::CHR_A) || ($urandom_range(0, 1) == 1);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
            put_file($urandom_range(0, 3) == 0, named, letter, n, 16'(pick_length()), WHOLE);
            if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) put_byte(8'h00);
         end
         file_no++;
      end

      sync = ($urandom_range(0, 1) == 1);
      n = $urandom_range(0, 6);
      case (closing)
         CLOSE_END_IN_NAME: begin
            put_file(sync, 1'b1, tif_pkg::CHR_B, n, 16'd0, 1 + $urandom_range(0, n));
            put_end();
         end
         CLOSE_ZERO_IN_NAME: begin
            put_file(sync, 1'b1, tif_pkg::CHR_M, n, 16'd0, 1 + $urandom_range(0, n));
            put_byte(8'h00);
         end
         CLOSE_BAD_START: begin
            do c = random_byte();
            while (c == 8'h00 || c == tif_pkg::CHR_SYNC || c == tif_pkg::CHR_QUOTE ||
                   c == tif_pkg::CHR_A);
            put_byte(c);
         end
         CLOSE_BAD_AFTER_SYNC: begin
            put_byte(tif_pkg::CHR_SYNC);
            case ($urandom_range(0, 2))
               0: put_end();
               1: put_byte(tif_pkg::CHR_SYNC);
               default: begin
                  do c = random_byte(); while (c == tif_pkg::CHR_QUOTE || c == tif_pkg::CHR_A);
                  put_byte(c);
               end
            endcase
         end
         CLOSE_END_BEFORE_TYPE: begin
            put_file(sync, 1'b1, tif_pkg::CHR_M, n, 16'd0, n + 2);
            put_end();
         end
         CLOSE_END_IN_A_HEADER: begin
            named = ($urandom_range(0, 1) == 1);
            put_file(sync, named, tif_pkg::CHR_A, n, 16'd0,
                     file_head(named, tif_pkg::CHR_A, n) - 4 + $urandom_range(0, 3));
            put_end();
         end
         CLOSE_END_IN_BM_HEADER: begin
            letter = ($urandom_range(0, 1) == 1) ? tif_pkg::CHR_B : tif_pkg::CHR_M;
            put_file(sync, 1'b1, letter, n, 16'd0,
                     file_head(1'b1, letter, n) - 2 + $urandom_range(0, 1));
            put_end();
         end
         CLOSE_BAD_TYPE: begin
            put_file(sync, 1'b1, tif_pkg::CHR_B, n, 16'd0, n + 2);
            do c = random_byte();
            while (c == tif_pkg::CHR_A || c == tif_pkg::CHR_B || c == tif_pkg::CHR_M);
            put_byte(c);
         end
         CLOSE_END_IN_BODY: begin
            letter = pick_letter();
            named = (letter != tif_pkg::CHR_A) || ($urandom_range(0, 1) == 1);
            len = pick_length();
            put_file(sync, named, letter, n, 16'(len), file_head(named, letter, n)
                     + $urandom_range(0, len + body_extra(letter) - 1));
            put_end();
         end
         default: put_end();
      endcase
      repeat (12) begin
         if ($urandom_range(0, 3) == 0) put_end();
         else put_byte(random_byte());
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      tx_calm = 0;
      foreach (tape_items[i]) begin
         gap = 0;
         if (tx_calm > 0) tx_calm--;
         else if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 200);
         else gap = idle_cycles();
         offer(tape_items[i], gap);
      end
      req_valid <= 1'b0;

      while (sb.outstanding() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d requests over %0d files: %0d name bytes, %0d body bytes, %0d closed",
               tape_items.size(), file_no, sb.name_bytes, sb.body_bytes, sb.files_closed);
      $display("image closed as %s, parser state %s, error code %0d",
               closing.name(), sb.state.name(), sb.halt_code);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // The receiver holds off once for a long stretch so that the parser fills and stalls requests.
   initial begin
      int stall;
      int rx_calm;
      int taken;
      int squeeze_at;
      rx_calm = 0;
      taken = 0;
      squeeze_at = $urandom_range(50, 400);
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            taken++;
            stall = 0;
            if (taken == squeeze_at) stall = HOLD_CYCLES;
            else if (rx_calm > 0) rx_calm--;
            else if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 200);
            else stall = idle_cycles();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      repeat (15_000_000) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
